// ===== design/bsa_pkg.sv =====
// Shared types, constants and helpers for the bitmap sub-block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

    // Cache geometry
    localparam int CACHE_SLOTS         = 4;
    localparam int SUBBLOCKS_PER_BLOCK = 64;
    localparam int LG_W                = 3;
    localparam int POS_W               = 6;
    localparam int SLOT_W              = 2;
    localparam logic [LG_W-1:0] LG_MAX = 3'd6;

    typedef logic [SUBBLOCKS_PER_BLOCK-1:0] mask_t;

    // Command codes; the fourth code is unused
    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_RETURN = 2'd2
    } cmd_e;

    // Result status codes
    typedef enum logic [2:0] {
        ST_CACHED   = 3'd0,
        ST_NEW_SLOT = 3'd1,
        ST_UNCACHED = 3'd2,
        ST_FREED    = 3'd3,
        ST_RECACHED = 3'd4,
        ST_RELEASED = 3'd5
    } status_e;

    // One request as held in the input register
    typedef struct packed {
        logic [1:0]        cmd;
        logic [LG_W-1:0]   size_log2;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  run_first;
        logic              owned_slot_valid;
    } req_t;

    // One result as held in the output register
    typedef struct packed {
        status_e           status;
        logic [SLOT_W-1:0] slot_out;
        logic [POS_W-1:0]  first_out;
    } rsp_t;

    // Run of 2^lg ones at bit 0; lg of 6 or more covers the whole block
    function automatic mask_t run_bits(input logic [LG_W-1:0] lg);
        mask_t r;
        case (lg)
            3'd0:    r = mask_t'(64'h0000_0000_0000_0001);
            3'd1:    r = mask_t'(64'h0000_0000_0000_0003);
            3'd2:    r = mask_t'(64'h0000_0000_0000_000F);
            3'd3:    r = mask_t'(64'h0000_0000_0000_00FF);
            3'd4:    r = mask_t'(64'h0000_0000_0000_FFFF);
            3'd5:    r = mask_t'(64'h0000_0000_FFFF_FFFF);
            default: r = '1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/bsa_run_find.sv =====
// Lowest aligned run of 2^lg free sub-blocks within one free mask.
`timescale 1ns / 1ps
`default_nettype none

module bsa_run_find (
    input  var bsa_pkg::mask_t                 mask,
    input  var logic [bsa_pkg::LG_W-1:0]       lg,
    output logic                               found,
    output logic [bsa_pkg::POS_W-1:0]          pos
);

    localparam int NB   = bsa_pkg::SUBBLOCKS_PER_BLOCK;
    localparam int NLVL = bsa_pkg::POS_W + 1;

    bsa_pkg::mask_t                lvl [NLVL];
    bsa_pkg::mask_t                vec;
    bsa_pkg::mask_t                low;
    logic [bsa_pkg::POS_W-1:0]     idx;

    // Build AND tree: level k bit j is set when aligned group j of 2^k is all free
    always_comb begin
        lvl[0] = mask;
        for (int k = 1; k < NLVL; k++) begin
            lvl[k] = '0;
            for (int j = 0; j < (NB >> k); j++) begin
                lvl[k][j] = lvl[k-1][2*j] & lvl[k-1][2*j+1];
            end
        end
    end

    // Pick the level for the requested size
    always_comb begin
        vec = '0;
        for (int k = 0; k < NLVL; k++) begin
            if (lg == bsa_pkg::LG_W'(k)) begin
                vec = lvl[k];
            end
        end
    end

    // Isolate the lowest set group and encode its index
    always_comb begin
        low = vec & (~vec + bsa_pkg::mask_t'(1));
        idx = '0;
        for (int j = 0; j < NB; j++) begin
            if (low[j]) begin
                idx = idx | bsa_pkg::POS_W'(j);
            end
        end
    end

    assign found = |vec;
    assign pos   = idx << lg;

endmodule

`default_nettype wire

// ===== design/bsa_core.sv =====
// Slot state and single-pass allocate, free and return decision.
`timescale 1ns / 1ps
`default_nettype none

module bsa_core #(
    parameter int CACHE_SLOTS = bsa_pkg::CACHE_SLOTS
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  var bsa_pkg::req_t req,
    input  wire               adv,
    output bsa_pkg::rsp_t     rsp
);

    localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

    logic [CACHE_SLOTS-1:0]        occ_reg;
    logic [CACHE_SLOTS-1:0]        occ_next;
    bsa_pkg::mask_t                mask_reg  [CACHE_SLOTS];
    bsa_pkg::mask_t                mask_next [CACHE_SLOTS];

    logic [bsa_pkg::LG_W-1:0]      lg_sat;
    bsa_pkg::mask_t                run;
    bsa_pkg::mask_t                clr_bits;
    bsa_pkg::mask_t                free_bits;
    logic [CACHE_SLOTS-1:0]        fnd;
    logic [bsa_pkg::POS_W-1:0]     fpos [CACHE_SLOTS];

    logic                          a_hit;
    logic [IDX_W-1:0]              a_idx;
    logic [bsa_pkg::POS_W-1:0]     a_pos;
    logic                          e_hit;
    logic [IDX_W-1:0]              e_idx;
    logic                          r_hit;
    logic [IDX_W-1:0]              r_idx;

    // Saturate oversize run length to a whole block
    assign lg_sat    = (req.size_log2 > bsa_pkg::LG_MAX) ? bsa_pkg::LG_MAX : req.size_log2;
    assign run       = bsa_pkg::run_bits(lg_sat);
    assign free_bits = run << req.run_first;

    // Search every slot mask in parallel
    for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_find
        bsa_run_find u_find (
            .mask  (mask_reg[g]),
            .lg    (lg_sat),
            .found (fnd[g]),
            .pos   (fpos[g])
        );
    end

    // Pick highest fitting slot, highest empty slot and highest return target
    always_comb begin
        a_hit = 1'b0;
        a_idx = '0;
        a_pos = '0;
        e_hit = 1'b0;
        e_idx = '0;
        r_hit = 1'b0;
        r_idx = '0;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (occ_reg[i] && fnd[i]) begin
                a_hit = 1'b1;
                a_idx = IDX_W'(i);
                a_pos = fpos[i];
            end
            if (!occ_reg[i]) begin
                e_hit = 1'b1;
                e_idx = IDX_W'(i);
            end
            if (!occ_reg[i] || (req.owned_slot_valid && (32'(req.slot) == i))) begin
                r_hit = 1'b1;
                r_idx = IDX_W'(i);
            end
        end
    end

    // A fresh block always allocates from sub-block zero
    assign clr_bits = run << (a_hit ? a_pos : bsa_pkg::POS_W'(0));

    // Decide the result and the next slot state
    always_comb begin
        rsp.status    = bsa_pkg::ST_FREED;
        rsp.slot_out  = '0;
        rsp.first_out = '0;
        occ_next      = occ_reg;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            mask_next[i] = mask_reg[i];
        end
        case (req.cmd)
            bsa_pkg::CMD_ALLOC: begin
                if (a_hit) begin
                    rsp.status    = bsa_pkg::ST_CACHED;
                    rsp.slot_out  = bsa_pkg::SLOT_W'(a_idx);
                    rsp.first_out = a_pos;
                    for (int i = 0; i < CACHE_SLOTS; i++) begin
                        if (a_idx == IDX_W'(i)) begin
                            mask_next[i] = mask_reg[i] & ~clr_bits;
                        end
                    end
                end else if (e_hit) begin
                    rsp.status   = bsa_pkg::ST_NEW_SLOT;
                    rsp.slot_out = bsa_pkg::SLOT_W'(e_idx);
                    for (int i = 0; i < CACHE_SLOTS; i++) begin
                        if (e_idx == IDX_W'(i)) begin
                            occ_next[i]  = 1'b1;
                            mask_next[i] = ~clr_bits;
                        end
                    end
                end else begin
                    rsp.status = bsa_pkg::ST_UNCACHED;
                end
            end
            bsa_pkg::CMD_FREE: begin
                rsp.status   = bsa_pkg::ST_FREED;
                rsp.slot_out = req.slot;
                // Drop frees to slots that are out of range or empty
                for (int i = 0; i < CACHE_SLOTS; i++) begin
                    if ((32'(req.slot) == i) && occ_reg[i]) begin
                        mask_next[i] = mask_reg[i] | free_bits;
                    end
                end
            end
            bsa_pkg::CMD_RETURN: begin
                if (r_hit) begin
                    rsp.status   = bsa_pkg::ST_RECACHED;
                    rsp.slot_out = bsa_pkg::SLOT_W'(r_idx);
                    for (int i = 0; i < CACHE_SLOTS; i++) begin
                        if (r_idx == IDX_W'(i)) begin
                            occ_next[i]  = 1'b1;
                            mask_next[i] = '1;
                        end
                    end
                end else begin
                    rsp.status = bsa_pkg::ST_RELEASED;
                end
            end
            default: begin
                rsp.status = bsa_pkg::ST_FREED;
            end
        endcase
    end

    // Hold occupancy; clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (adv) begin
            occ_reg <= occ_next;
        end
    end

    // Hold masks; an empty slot's search result is never used, so no reset is needed
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                mask_reg[i] <= mask_next[i];
            end
        end
    end

    // A new-slot allocation fills exactly one more slot
    a_new_slot_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && rsp.status == bsa_pkg::ST_NEW_SLOT)
        |=> $countones(occ_reg) == $countones($past(occ_reg)) + 1)
        else $error("new-slot allocation did not fill one slot");

    // Uncached whole allocation only when every slot is occupied
    a_uncached_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && rsp.status == bsa_pkg::ST_UNCACHED) |-> (&occ_reg))
        else $error("uncached allocation with an empty slot");

    // Release only when every slot is occupied
    a_release_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && rsp.status == bsa_pkg::ST_RELEASED) |-> (&occ_reg))
        else $error("block released with an empty slot");

    // Occupied slots never become empty
    a_occ_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> ((occ_reg & $past(occ_reg)) == $past(occ_reg)))
        else $error("occupied slot was emptied");

endmodule

`default_nettype wire

// ===== design/bitmap_subblock_allocator.sv =====
// Top level: input register, allocator core and result register.
// Path: an accepted item is held in the input register and passes through the core into the result register on adv.
// Throughput: 1 item per cycle while m_ready is high; the parallel run search over all slot
// masks completes in the single pass between the two registers.
// Reset: synchronous, active low; clears all slot occupancy and both valid flags.
// Free masks carry no reset; a mask's search result is only used once its slot is occupied.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_subblock_allocator #(
    parameter int CACHE_SLOTS = bsa_pkg::CACHE_SLOTS
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [1:0]                        s_cmd,
    input  wire  [bsa_pkg::LG_W-1:0]          s_size_log2,
    input  wire  [bsa_pkg::SLOT_W-1:0]        s_slot,
    input  wire  [bsa_pkg::POS_W-1:0]         s_run_first,
    input  wire                               s_owned_slot_valid,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [2:0]                        m_status,
    output logic [bsa_pkg::SLOT_W-1:0]        m_slot_out,
    output logic [bsa_pkg::POS_W-1:0]         m_first_out
);

    logic            in_valid_reg;
    logic            in_valid_next;
    bsa_pkg::req_t   req_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    bsa_pkg::rsp_t   rsp_reg;
    bsa_pkg::rsp_t   rsp;
    logic            adv;
    logic            s_fire;

    // Advance the held item when the result register is free or draining
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
    assign out_valid_next = adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.cmd              <= s_cmd;
            req_reg.size_log2        <= s_size_log2;
            req_reg.slot             <= s_slot;
            req_reg.run_first        <= s_run_first;
            req_reg.owned_slot_valid <= s_owned_slot_valid;
        end
    end

    bsa_core #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .adv     (adv),
        .rsp     (rsp)
    );

    // Load the result register
    always_ff @(posedge aclk) begin
        if (adv) begin
            rsp_reg <= rsp;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = rsp_reg.status;
    assign m_slot_out  = rsp_reg.slot_out;
    assign m_first_out = rsp_reg.first_out;

endmodule

`default_nettype wire
